### rtl/chkv_pkg.sv
// Shared types and constants for the chained hash key-value store.
package chkv_pkg;

    localparam int unsigned BUCKETS     = 64;
    localparam int unsigned CHAIN_DEPTH = 8;
    localparam int unsigned SLOT_TOTAL  = BUCKETS * CHAIN_DEPTH;
    localparam int unsigned SLOT_W      = $clog2(SLOT_TOTAL);
    localparam int unsigned CHAIN_W     = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int unsigned BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned CFG_W       = 7;
    localparam int unsigned CNT_W       = 10;
    localparam int unsigned MOD_STEPS   = 32;
    localparam int unsigned STEP_W      = $clog2(MOD_STEPS + 1);
    localparam logic [31:0] MIX_MUL     = 32'h045d_9f3b;
    localparam int unsigned MIX_SHIFT   = 16;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_UPDATED  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic mix1;
        logic mix2;
        logic mod_start;
        logic mod_step;
        logic scan_clear;
        logic scan_read;
        logic scan_eval;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic scan_last;
    } t_sts;

endpackage

### rtl/chkv_datapath.sv
// Datapath: key mixer, serial modulo, slot memories, chain scan and update.
module chkv_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  chkv_pkg::t_cmd              i_cmd,
    output chkv_pkg::t_sts              o_sts,
    input  logic [chkv_pkg::CFG_W-1:0]  i_buckets,
    input  logic [1:0]                  i_opcode,
    input  logic [31:0]                 i_key,
    input  logic [31:0]                 i_value,
    output logic                        o_found,
    output logic [31:0]                 o_value,
    output logic [1:0]                  o_status,
    output logic [chkv_pkg::CNT_W-1:0]  o_count
);
    import chkv_pkg::*;

    logic [31:0]        slot_keys   [SLOT_TOTAL];
    logic [31:0]        slot_values [SLOT_TOTAL];
    logic [SLOT_TOTAL-1:0] r_valid;
    logic [31:0]        r_rd_key;
    logic [31:0]        r_rd_value;
    logic               r_rd_valid;

    logic [1:0]         r_op;
    logic [31:0]        r_key;
    logic [31:0]        r_val;
    logic [31:0]        r_h;
    logic [31:0]        r_rem;
    logic [STEP_W-1:0]  r_step;
    logic [BKT_W-1:0]   r_bucket;
    logic [CHAIN_W:0]   r_idx;
    logic [CHAIN_W-1:0] r_eval_idx;
    logic               r_hit;
    logic               r_free;
    logic [CHAIN_W-1:0] r_hit_idx;
    logic [CHAIN_W-1:0] r_free_idx;
    logic [31:0]        r_hit_val;
    logic [CNT_W-1:0]   r_count;

    logic [31:0]        eff;
    logic [31:0]        xs;
    logic [32:0]        trial;
    logic [32:0]        rem_sh;
    logic [SLOT_W-1:0]  base;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  hit_addr;
    logic [SLOT_W-1:0]  free_addr;

    always_comb begin
        if (i_buckets == '0) begin
            eff = 32'd1;
        end else if (32'(i_buckets) > BUCKETS) begin
            eff = 32'(BUCKETS);
        end else begin
            eff = 32'(i_buckets);
        end
        xs       = (r_h >> MIX_SHIFT) ^ r_h;
        rem_sh   = {r_rem, r_h[31 - 5'(r_step)]};
        trial    = rem_sh - {1'b0, eff};
        base     = SLOT_W'(r_bucket) * SLOT_W'(CHAIN_DEPTH);
        rd_addr  = base + SLOT_W'(r_idx[CHAIN_W-1:0]);
        hit_addr = base + SLOT_W'(r_hit_idx);
        free_addr = base + SLOT_W'(r_free_idx);
    end

    assign o_sts.mod_done  = (r_step == STEP_W'(MOD_STEPS));
    assign o_sts.scan_last = (r_idx == (CHAIN_W+1)'(CHAIN_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_val <= i_value;
            r_h   <= i_key;
        end
        if (i_cmd.mix1 || i_cmd.mix2) begin
            r_h <= xs * MIX_MUL;
        end
        if (i_cmd.mod_start) begin
            r_h    <= xs;
            r_rem  <= '0;
            r_step <= '0;
        end
        if (i_cmd.mod_step) begin
            r_step <= r_step + 1'b1;
            if (!trial[32]) begin
                r_rem <= trial[31:0];
            end else begin
                r_rem <= rem_sh[31:0];
            end
        end
        if (i_cmd.scan_clear) begin
            r_bucket <= BKT_W'(r_rem);
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end
        if (i_cmd.scan_read) begin
            r_rd_key   <= slot_keys[rd_addr];
            r_rd_value <= slot_values[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
            r_eval_idx <= r_idx[CHAIN_W-1:0];
            r_idx      <= r_idx + 1'b1;
        end
        if (i_cmd.scan_eval) begin
            if (r_rd_valid) begin
                if (!r_hit && r_rd_key == r_key) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_eval_idx;
                    r_hit_val <= r_rd_value;
                end
            end else if (!r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_eval_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_op == OP_PUT) begin
            if (r_hit) begin
                slot_values[hit_addr] <= r_val;
            end else if (r_free) begin
                slot_keys[free_addr]   <= r_key;
                slot_values[free_addr] <= r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (r_op == OP_PUT && !r_hit && r_free) begin
                r_valid[free_addr] <= 1'b1;
                r_count            <= r_count + 1'b1;
            end else if (r_op == OP_REMOVE && r_hit) begin
                r_valid[hit_addr] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_found  <= 1'b0;
            o_value  <= '0;
            o_status <= ST_DONE;
            case (r_op)
                OP_PUT: begin
                    o_found  <= r_hit;
                    o_status <= r_hit ? ST_UPDATED : (r_free ? ST_DONE : ST_FULL);
                end
                OP_GET: begin
                    o_found  <= r_hit;
                    o_value  <= r_hit ? r_hit_val : '0;
                    o_status <= r_hit ? ST_DONE : ST_NOTFOUND;
                end
                OP_REMOVE: begin
                    o_found  <= r_hit;
                    o_status <= r_hit ? ST_DONE : ST_NOTFOUND;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_count = r_count;

endmodule

### rtl/chkv_ctrl.sv
// Controller: sequences hash, modulo, chain scan and commit for one item.
module chkv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output chkv_pkg::t_cmd o_cmd,
    input  chkv_pkg::t_sts i_sts
);
    import chkv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MIX1, S_MIX2, S_MODS, S_MOD, S_SCAN, S_COMMIT, S_OUT
    } t_state;

    t_state r_state;
    logic   r_eval;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mix1       = (r_state == S_MIX1);
        o_cmd.mix2       = (r_state == S_MIX2);
        o_cmd.mod_start  = (r_state == S_MODS);
        o_cmd.mod_step   = (r_state == S_MOD) && !i_sts.mod_done;
        o_cmd.scan_clear = (r_state == S_MOD) && i_sts.mod_done;
        o_cmd.scan_read  = (r_state == S_SCAN) && !i_sts.scan_last;
        o_cmd.scan_eval  = r_eval;
        o_cmd.commit     = (r_state == S_COMMIT) && !r_eval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eval  <= 1'b0;
        end else begin
            r_eval <= 1'b0;
            unique case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_MIX1;
                S_MIX1:   r_state <= S_MIX2;
                S_MIX2:   r_state <= S_MODS;
                S_MODS:   r_state <= S_MOD;
                S_MOD:    if (i_sts.mod_done) r_state <= S_SCAN;
                S_SCAN: begin
                    if (i_sts.scan_last) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_eval <= 1'b1;
                    end
                end
                S_COMMIT: if (!r_eval) r_state <= S_OUT;
                S_OUT:    if (i_out_ready) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.mix1, o_cmd.mix2, o_cmd.mod_step, o_cmd.scan_read, o_cmd.commit}))
        else $error("overlapping datapath commands");
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("result not shown after commit");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped");
`endif

endmodule

### rtl/chained_hash_key_value_store.sv
// Top level of the chained hash key-value store.
// Each item passes through three mix steps, a serial modulo, a chain scan
// and a commit before its result is shown; one item in flight, so a new
// item is accepted only after the result has been taken.
// Reset (synchronous, active low) clears all slot valid marks and the count
// at once and sets the bucket count to 64.
module chained_hash_key_value_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // opcode, key, value_in, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // found, value_out, status, entry_count, zero pad
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);
    import chkv_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [CFG_W-1:0] r_buckets;
    logic             found;
    logic [31:0]      value_out;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buckets <= CFG_W'(64);
        end else if (i_cfg_we) begin
            r_buckets <= i_cfg_wdata;
        end
    end

    chkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    chkv_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_buckets (r_buckets),
        .i_opcode  (s_axis_tdata[1:0]),
        .i_key     (s_axis_tdata[33:2]),
        .i_value   (s_axis_tdata[65:34]),
        .o_found   (found),
        .o_value   (value_out),
        .o_status  (status),
        .o_count   (count)
    );

    assign m_axis_tdata = {3'b000, count, status, value_out, found};

endmodule

### bench/tb_top.sv
// Testbench for the chained hash key-value store: a scoreboard-based stream check.
module tb_top;
    import chkv_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // opcode, key, value_in, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // found, value_out, status, entry_count, zero pad
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;

    bit          failed = 1'b0;
    bit          calm = 1'b0;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [9:0]  entry_count;
    } t_reply;

    class kv_scoreboard;
        logic [31:0] keys [SLOT_TOTAL];
        logic [31:0] vals [SLOT_TOTAL];
        bit          valid [SLOT_TOTAL];
        int unsigned held;
        logic [6:0]  bucket_cfg;
        t_reply      pending [$];

        function void clear();
            foreach (valid[i]) valid[i] = 1'b0;
            held = 0;
            bucket_cfg = 7'd64;
            pending.delete();
        endfunction

        function logic [31:0] mix(logic [31:0] h);
            h = ((h >> MIX_SHIFT) ^ h) * 32'h045d_9f3b;
            h = ((h >> MIX_SHIFT) ^ h) * 32'h045d_9f3b;
            return (h >> MIX_SHIFT) ^ h;
        endfunction

        function int unsigned bucket_of(logic [31:0] key);
            int unsigned n;
            n = bucket_cfg;
            if (n == 0) n = 1;
            if (n > BUCKETS) n = BUCKETS;
            return mix(key) % n;
        endfunction

        function void note_item(t_opcode op, logic [31:0] key, logic [31:0] val);
            int unsigned base;
            int hit;
            int free_s;
            t_reply r;
            base = bucket_of(key) * CHAIN_DEPTH;
            hit = -1;
            free_s = -1;
            r = '0;
            for (int i = 0; i < CHAIN_DEPTH; i++) begin
                if (valid[base+i]) begin
                    if (hit < 0 && keys[base+i] == key) hit = base + i;
                end else if (free_s < 0) begin
                    free_s = base + i;
                end
            end
            case (op)
                OP_PUT: begin
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        vals[hit] = val;
                        r.status = ST_UPDATED;
                    end else if (free_s >= 0) begin
                        keys[free_s] = key;
                        vals[free_s] = val;
                        valid[free_s] = 1'b1;
                        held++;
                        r.status = ST_DONE;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                OP_GET: begin
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        r.value_out = vals[hit];
                        r.status = ST_DONE;
                    end else begin
                        r.status = ST_NOTFOUND;
                    end
                end
                OP_REMOVE: begin
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        valid[hit] = 1'b0;
                        if (held > 0) held--;
                        r.status = ST_DONE;
                    end else begin
                        r.status = ST_NOTFOUND;
                    end
                end
                default: r.status = ST_DONE;
            endcase
            r.entry_count = held[9:0];
            pending.push_back(r);
        endfunction

        function bit check_reply(logic [47:0] data);
            t_reply got;
            t_reply exp;
            bit bad;
            got.found = data[0];
            got.value_out = data[32:1];
            got.status = data[34:33];
            got.entry_count = data[44:35];
            bad = 1'b0;
            if (pending.size() == 0) begin
                $error("unexpected result item %h", data);
                return 1'b1;
            end
            exp = pending.pop_front();
            if (got.found !== exp.found) begin
                $error("found: expected %0d actual %0d", exp.found, got.found);
                bad = 1'b1;
            end
            if (got.value_out !== exp.value_out) begin
                $error("value_out: expected %h actual %h", exp.value_out, got.value_out);
                bad = 1'b1;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d actual %0d", exp.status, got.status);
                bad = 1'b1;
            end
            if (got.entry_count !== exp.entry_count) begin
                $error("entry_count: expected %0d actual %0d", exp.entry_count,
                       got.entry_count);
                bad = 1'b1;
            end
            return bad;
        endfunction
    endclass

    kv_scoreboard board = new();
    logic [31:0] key_pool [16];

    chained_hash_key_value_store dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (board.check_reply(m_axis_tdata)) failed = 1'b1;
        end
    end

    // random receiver stalls in bursts
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_item(t_opcode op, logic [31:0] key, logic [31:0] val);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, val, key, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(op, key, val);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [6:0] n);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.bucket_cfg = n;
    endtask

    task automatic random_phase(int count);
        t_opcode op;
        logic [31:0] key;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) op = OP_PUT;
            else if (r < 75) op = OP_GET;
            else if (r < 97) op = OP_REMOVE;
            else op = OP_NONE;
            key = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 15)];
            send_item(op, key, $urandom());
        end
    endtask

    initial begin
        board.clear();
        foreach (key_pool[i]) key_pool[i] = $urandom();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, all opcodes, update, miss, unused opcode
        send_item(OP_GET, 32'h0, 32'h0);
        send_item(OP_PUT, 32'h0, 32'hFFFF_FFFF);
        send_item(OP_PUT, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_PUT, 32'h0, 32'h1234_5678);
        send_item(OP_GET, 32'h0, 32'hFFFF_FFFF);
        send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 32'h0, 32'h0);
        send_item(OP_REMOVE, 32'h0, 32'h0);
        send_item(OP_GET, 32'h0, 32'h0);
        // zero acts as one bucket: fill it past its depth
        write_buckets(7'd0);
        for (int i = 0; i < 10; i++) send_item(OP_PUT, 32'hA000_0000 + i, i);
        send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_GET, 32'hA000_0003, 32'h0);
        // saturating count, then entries left in other buckets
        write_buckets(7'd127);
        send_item(OP_GET, 32'hA000_0003, 32'h0);
        random_phase(250);
        write_buckets(7'd1);
        random_phase(150);
        write_buckets(7'd3);
        random_phase(200);
        write_buckets(7'd64);
        random_phase(200);
        write_buckets(7'd65);
        random_phase(150);
        calm = 1'b1;
        random_phase(170);
        drain();
        if (!failed) begin
            $display("[chained_hash_key_value_store] OK");
        end else begin
            $display("[chained_hash_key_value_store] ERROR");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("[chained_hash_key_value_store] ERROR");
        $finish;
    end
endmodule
